FILE: sv/cban_pkg.sv
// Package for the coarse boundary area and normal block.
// Holds the sequencer state type and the fixed datapath widths.
// No dependencies; used by coarsen_boundary_area_normal.
package cban_pkg;

    // Field widths of the input and result beats.
    localparam int AREA_IN_W  = 17;
    localparam int NORMAL_W   = 18;
    localparam int AREA_OUT_W = 18;

    // Accumulator, shared multiplier and sum widths.
    localparam int ACC_W = 22;
    localparam int MUL_W = 23;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W = 48;

    // Square root: 44-bit radicand, one result bit per iteration.
    localparam int RAD_W   = 44;
    localparam int ROOT_W  = 22;
    localparam int SQ_ITER = 22;
    localparam int LEN_W   = 23;
    localparam int REM_W   = 24;

    // Shared trial subtractor width.
    localparam int SUB_W = 26;

    // Iteration and dimension counter widths.
    localparam int ITER_W = 5;
    localparam int DIM_W  = 2;
    localparam int NUM_AXES = 3;

    // Largest coarse area that fits the result field.
    localparam logic [LEN_W-1:0] AREA_MAX = LEN_W'((1 << AREA_OUT_W) - 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_SQMUL,
        ST_SQADD,
        ST_SQRT,
        ST_ROUND,
        ST_DIVLD,
        ST_DIV,
        ST_DIVEND,
        ST_DONE
    } cban_state_t;

endpackage

FILE: sv/coarsen_boundary_area_normal.sv
// Coarse boundary area and unit normal from a stream of fine cut cells.
// Depends on cban_pkg for the state type and fixed widths.
//
//  channel | handshake           | fields
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid / in_ready | fine_area, fine_normal_x/y/z, last_fine
//  output  | out_valid/out_ready | coarse_area, coarse_normal_x/y/z
//
// A fine cell beat is accepted, then takes one multiply and one accumulate
// step per axis on the shared multiplier. A beat marked last adds a scaling
// step, a square and an add per axis, the square root, one rounding step, a
// divide per axis when the area is nonzero and a step to load the output
// register.
// The result sits in an output register; a new fine cell is taken while it
// waits, and only the next finished coarse cell stalls on out_ready.
// Reset clears the accumulators, the sequencer and the output valid flag.
module coarsen_boundary_area_normal #(
    parameter int SPACE_DIM = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic        [cban_pkg::AREA_IN_W-1:0] fine_area,
    input  logic signed [cban_pkg::NORMAL_W-1:0]  fine_normal_x,
    input  logic signed [cban_pkg::NORMAL_W-1:0]  fine_normal_y,
    input  logic signed [cban_pkg::NORMAL_W-1:0]  fine_normal_z,
    input  logic                                  last_fine,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [cban_pkg::AREA_OUT_W-1:0] coarse_area,
    output logic signed [cban_pkg::NORMAL_W-1:0]  coarse_normal_x,
    output logic signed [cban_pkg::NORMAL_W-1:0]  coarse_normal_y,
    output logic signed [cban_pkg::NORMAL_W-1:0]  coarse_normal_z
);

    localparam int ACC_W  = cban_pkg::ACC_W;
    localparam int MUL_W  = cban_pkg::MUL_W;
    localparam int PROD_W = cban_pkg::PROD_W;
    localparam int SUM_W  = cban_pkg::SUM_W;
    localparam int REM_W  = cban_pkg::REM_W;
    localparam int ROOT_W = cban_pkg::ROOT_W;
    localparam int LEN_W  = cban_pkg::LEN_W;
    localparam int RAD_W  = cban_pkg::RAD_W;
    localparam int SUB_W  = cban_pkg::SUB_W;
    localparam int NRM_W  = cban_pkg::NORMAL_W;
    localparam int ITER_W = cban_pkg::ITER_W;
    localparam int DIM_W  = cban_pkg::DIM_W;

    // Rounding constants for the product shift and the dimension scaling.
    localparam int SC_SH = SPACE_DIM - 1;
    localparam logic [PROD_W:0] MUL_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W:0] SC_HALF =
        (SPACE_DIM > 1) ? ((ACC_W + 1)'(1) << (SC_SH - 1)) : (ACC_W + 1)'(0);

    // Division numerator and quotient widths.
    localparam int NUM_W = ACC_W + FRAC_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int QS_W  = (FRAC_BITS + 2 > NRM_W) ? FRAC_BITS + 2 : NRM_W;

    localparam logic [DIM_W-1:0]  LAST_DIM  = DIM_W'(SPACE_DIM - 1);
    localparam logic [ITER_W-1:0] SQ_LAST   = ITER_W'(cban_pkg::SQ_ITER - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(FRAC_BITS);
    localparam logic [Q_W-1:0]    Q_ONE     = {1'b1, {FRAC_BITS{1'b0}}};

    cban_pkg::cban_state_t state_reg, state_next;

    // Latched input beat.
    logic        [cban_pkg::AREA_IN_W-1:0] area_reg;
    logic signed [NRM_W-1:0]               nin_reg [cban_pkg::NUM_AXES];
    logic                                  last_reg;

    // Accumulators, reused for the scaled vector on a last beat.
    logic signed [ACC_W-1:0] acc_reg [cban_pkg::NUM_AXES];

    // Sequencer counters and iterative unit registers.
    logic [DIM_W-1:0]        dim_reg;
    logic [ITER_W-1:0]       it_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [Q_W-1:0]          nq_reg;
    logic                    neg_reg;
    logic signed [NRM_W-1:0] nrm_reg [cban_pkg::NUM_AXES];

    // Output register.
    logic                    out_valid_reg;
    logic [cban_pkg::AREA_OUT_W-1:0] oarea_reg;
    logic signed [NRM_W-1:0] onrm_reg [cban_pkg::NUM_AXES];

    // Control decode.
    logic in_fire;
    logic out_free;
    logic out_load;
    logic dim_last;
    logic len_zero;

    // Datapath signals.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W:0]          rnd_pre;
    logic signed [PROD_W:0]   rnd_val;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [ACC_W-1:0]  acc_cur;
    logic signed [ACC_W-1:0]  scaled   [cban_pkg::NUM_AXES];
    logic [ACC_W:0]           sc_pre   [cban_pkg::NUM_AXES];
    logic [SUB_W-1:0]         sub_a, sub_b;
    logic [SUB_W:0]           sub_d;
    logic                     sub_ge;
    logic [SUB_W-1:0]         sq_t;
    logic [SUB_W-1:0]         dv_t;
    logic [LEN_W-1:0]         len_rnd;
    logic [ACC_W-1:0]         s_mag;
    logic [NUM_W-1:0]         num_full;
    logic signed [QS_W-1:0]   q_pos;
    logic signed [QS_W-1:0]   q_sgn;
    logic [LEN_W-1:0]         area_sat;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cban_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cban_pkg::ST_MUL;
                end
            end
            cban_pkg::ST_MUL:
            begin
                state_next = cban_pkg::ST_ACC;
            end
            cban_pkg::ST_ACC:
            begin
                if (!dim_last)
                begin
                    state_next = cban_pkg::ST_MUL;
                end
                else if (last_reg)
                begin
                    state_next = cban_pkg::ST_SCALE;
                end
                else
                begin
                    state_next = cban_pkg::ST_IDLE;
                end
            end
            cban_pkg::ST_SCALE:
            begin
                state_next = cban_pkg::ST_SQMUL;
            end
            cban_pkg::ST_SQMUL:
            begin
                state_next = cban_pkg::ST_SQADD;
            end
            cban_pkg::ST_SQADD:
            begin
                state_next = dim_last ? cban_pkg::ST_SQRT : cban_pkg::ST_SQMUL;
            end
            cban_pkg::ST_SQRT:
            begin
                if (it_reg == SQ_LAST)
                begin
                    state_next = cban_pkg::ST_ROUND;
                end
            end
            cban_pkg::ST_ROUND:
            begin
                state_next = len_zero ? cban_pkg::ST_DONE : cban_pkg::ST_DIVLD;
            end
            cban_pkg::ST_DIVLD:
            begin
                state_next = cban_pkg::ST_DIV;
            end
            cban_pkg::ST_DIV:
            begin
                if (it_reg == DIV_LAST)
                begin
                    state_next = cban_pkg::ST_DIVEND;
                end
            end
            cban_pkg::ST_DIVEND:
            begin
                state_next = dim_last ? cban_pkg::ST_DONE : cban_pkg::ST_DIVLD;
            end
            cban_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cban_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cban_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready = (state_reg == cban_pkg::ST_IDLE);
        out_free = !out_valid_reg || out_ready;
        out_load = (state_reg == cban_pkg::ST_DONE) && out_free;
        dim_last = (dim_reg == LAST_DIM);
        len_zero = (root_reg == '0) && (rem_reg == '0);
    end

    assign in_fire = in_valid && in_ready;
    assign acc_cur = acc_reg[dim_reg];

    // Shared multiplier: fine area times normal, or scaled component squared.
    always_comb
    begin
        if (state_reg == cban_pkg::ST_SQMUL)
        begin
            mul_a = MUL_W'(acc_cur);
            mul_b = MUL_W'(acc_cur);
        end
        else
        begin
            mul_a = $signed({{(MUL_W - cban_pkg::AREA_IN_W){1'b0}}, area_reg});
            mul_b = MUL_W'(nin_reg[dim_reg]);
        end
        mul_p = mul_a * mul_b;
    end

    // Product rounding (ties away from zero) and saturating accumulate.
    always_comb
    begin
        rnd_pre = {prod_reg[PROD_W-1], prod_reg} + MUL_HALF
                  - {{PROD_W{1'b0}}, prod_reg[PROD_W-1]};
        rnd_val = $signed(rnd_pre) >>> FRAC_BITS;
        acc_sum = SUM_W'(acc_cur) + SUM_W'(rnd_val);
        if (acc_sum[SUM_W-1:ACC_W-1] == {(SUM_W - ACC_W + 1){acc_sum[SUM_W-1]}})
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        else
        begin
            acc_sat = {acc_sum[SUM_W-1], {(ACC_W - 1){!acc_sum[SUM_W-1]}}};
        end
    end

    // Scale each axis by 2^-(SPACE_DIM-1) with rounding.
    always_comb
    begin
        for (int i = 0; i < cban_pkg::NUM_AXES; i++)
        begin
            sc_pre[i] = {acc_reg[i][ACC_W-1], acc_reg[i]} + SC_HALF
                        - {{ACC_W{1'b0}}, acc_reg[i][ACC_W-1]};
            if (SC_SH == 0)
            begin
                scaled[i] = acc_reg[i];
            end
            else
            begin
                scaled[i] = ACC_W'($signed(sc_pre[i]) >>> SC_SH);
            end
        end
    end

    // Shared trial subtractor for the square root and the divider.
    always_comb
    begin
        sq_t = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        dv_t = {{(SUB_W - LEN_W - 1){1'b0}}, rem_reg[LEN_W-1:0], nq_reg[Q_W-1]};
        if (state_reg == cban_pkg::ST_SQRT)
        begin
            sub_a = sq_t;
            sub_b = {{(SUB_W - ROOT_W - 2){1'b0}}, root_reg, 2'b01};
        end
        else
        begin
            sub_a = dv_t;
            sub_b = {{(SUB_W - LEN_W){1'b0}}, len_reg};
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[SUB_W];
    end

    // Length rounding, numerator setup and signed quotient.
    always_comb
    begin
        len_rnd = {1'b0, root_reg};
        if (rem_reg > {{(REM_W - ROOT_W){1'b0}}, root_reg})
        begin
            len_rnd = {1'b0, root_reg} + LEN_W'(1);
        end
        s_mag    = acc_cur[ACC_W-1] ? ACC_W'(-acc_cur) : acc_cur;
        num_full = (NUM_W'(s_mag) << FRAC_BITS) + NUM_W'(len_reg >> 1);
        q_pos    = $signed({{(QS_W - Q_W){1'b0}}, nq_reg});
        q_sgn    = neg_reg ? -q_pos : q_pos;
        area_sat = (len_reg > cban_pkg::AREA_MAX) ? cban_pkg::AREA_MAX : len_reg;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cban_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Accumulators: reset to zero, cleared once a result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cban_pkg::NUM_AXES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (state_reg == cban_pkg::ST_ACC)
        begin
            acc_reg[dim_reg] <= acc_sat;
        end
        else if (state_reg == cban_pkg::ST_SCALE)
        begin
            for (int i = 0; i < cban_pkg::NUM_AXES; i++)
            begin
                if (i < SPACE_DIM)
                begin
                    acc_reg[i] <= scaled[i];
                end
            end
        end
        else if (out_load)
        begin
            for (int i = 0; i < cban_pkg::NUM_AXES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
    end

    // Counters of the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= '0;
            it_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                cban_pkg::ST_IDLE, cban_pkg::ST_SCALE:
                begin
                    dim_reg <= '0;
                end
                cban_pkg::ST_ACC, cban_pkg::ST_DIVEND:
                begin
                    dim_reg <= dim_last ? '0 : dim_reg + DIM_W'(1);
                end
                cban_pkg::ST_SQADD:
                begin
                    dim_reg <= dim_last ? '0 : dim_reg + DIM_W'(1);
                    it_reg  <= '0;
                end
                cban_pkg::ST_ROUND:
                begin
                    dim_reg <= '0;
                end
                cban_pkg::ST_DIVLD:
                begin
                    it_reg <= '0;
                end
                cban_pkg::ST_SQRT, cban_pkg::ST_DIV:
                begin
                    it_reg <= it_reg + ITER_W'(1);
                end
                default:
                begin
                    it_reg <= it_reg;
                end
            endcase
        end
    end

    // Input latch, product register and the iterative root and divide.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            area_reg   <= fine_area;
            nin_reg[0] <= fine_normal_x;
            nin_reg[1] <= fine_normal_y;
            nin_reg[2] <= fine_normal_z;
            last_reg   <= last_fine;
        end
        case (state_reg)
            cban_pkg::ST_MUL, cban_pkg::ST_SQMUL:
            begin
                prod_reg <= mul_p;
            end
            cban_pkg::ST_SCALE:
            begin
                rad_reg <= '0;
            end
            cban_pkg::ST_SQADD:
            begin
                rad_reg  <= rad_reg + prod_reg[RAD_W-1:0];
                root_reg <= '0;
                rem_reg  <= '0;
            end
            cban_pkg::ST_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                root_reg <= {root_reg[ROOT_W-2:0], sub_ge};
                rem_reg  <= sub_ge ? sub_d[REM_W-1:0] : sq_t[REM_W-1:0];
            end
            cban_pkg::ST_ROUND:
            begin
                len_reg <= len_rnd;
                for (int i = 0; i < cban_pkg::NUM_AXES; i++)
                begin
                    nrm_reg[i] <= '0;
                end
            end
            cban_pkg::ST_DIVLD:
            begin
                rem_reg <= REM_W'(num_full[NUM_W-1:Q_W]);
                nq_reg  <= num_full[Q_W-1:0];
                neg_reg <= acc_cur[ACC_W-1];
            end
            cban_pkg::ST_DIV:
            begin
                rem_reg <= sub_ge ? REM_W'(sub_d[LEN_W-1:0]) : REM_W'(dv_t[LEN_W-1:0]);
                nq_reg  <= {nq_reg[Q_W-2:0], sub_ge};
            end
            cban_pkg::ST_DIVEND:
            begin
                nrm_reg[dim_reg] <= q_sgn[NRM_W-1:0];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // Output register: valid flag and held result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            oarea_reg <= area_sat[cban_pkg::AREA_OUT_W-1:0];
            for (int i = 0; i < cban_pkg::NUM_AXES; i++)
            begin
                onrm_reg[i] <= nrm_reg[i];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign coarse_area     = oarea_reg;
    assign coarse_normal_x = onrm_reg[0];
    assign coarse_normal_y = onrm_reg[1];
    assign coarse_normal_z = onrm_reg[2];

`ifndef SYNTHESIS
    // Axes beyond the space dimension never accumulate anything.
    a_unused_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (SPACE_DIM < 3) |-> (acc_reg[2] == '0))
        else $error("unused axis accumulator is not zero");

    // A finished result waits while the output register is still full.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cban_pkg::ST_DONE && out_valid_reg && !out_ready)
        |=> (state_reg == cban_pkg::ST_DONE))
        else $error("result left the sequencer while output was occupied");

    // The quotient magnitude never exceeds one in fixed point.
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cban_pkg::ST_DIVEND) |-> (nq_reg <= Q_ONE))
        else $error("normal quotient above one");

    // The accumulators start from zero for the next coarse cell.
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0))
        else $error("accumulator not cleared after a result");
`endif

endmodule
